// ===== sv/nae_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nae_pkg
// Shared codes, register indexes and controller/datapath interface types for
// the note articulation event generator.
// ----------------------------------------------------------------------------
package nae_pkg;

	// Command codes of an input word.
	localparam logic [1:0] CMD_NOTE = 2'd0;
	localparam logic [1:0] CMD_REST = 2'd1;
	localparam logic [1:0] CMD_ECHO = 2'd2;
	localparam logic [1:0] CMD_NONE = 2'd3;

	// Event kinds of an output word.
	localparam logic [1:0] KIND_NOTE   = 2'd0;
	localparam logic [1:0] KIND_REST   = 2'd1;
	localparam logic [1:0] KIND_VOLUME = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] REG_DEFAULT_TICKS    = 3'd0;
	localparam logic [2:0] REG_QUANT_NUM        = 3'd1;
	localparam logic [2:0] REG_QUANT_DEN        = 3'd2;
	localparam logic [2:0] REG_RELEASE_TICKS    = 3'd3;
	localparam logic [2:0] REG_DRUM_ENABLE      = 3'd4;
	localparam logic [2:0] REG_SHUFFLE_AMOUNT   = 3'd5;
	localparam logic [2:0] REG_ECHO_OFFSET      = 3'd6;
	localparam logic [2:0] REG_ECHO_ATTENUATION = 3'd7;

	// Reset values of the configuration registers.
	localparam logic [15:0] DEFAULT_TICKS_RST = 16'd96;
	localparam logic [7:0]  QUANT_NUM_RST     = 8'd8;
	localparam logic [7:0]  QUANT_DEN_RST     = 8'd8;

	localparam logic [7:0] SEMITONES = 8'd12;

	// The quantize product is 24 bits wide and is divided one bit per cycle.
	localparam int         PROD_W   = 24;
	localparam logic [4:0] DIV_LAST = 5'd23;

	// Output slot of an item: volume drop, the note or rest, volume restore.
	localparam logic [1:0] SLOT_PRE  = 2'd0;
	localparam logic [1:0] SLOT_MAIN = 2'd1;
	localparam logic [1:0] SLOT_POST = 2'd2;

	typedef struct packed {
		logic       capture;
		logic       prep;
		logic       mul;
		logic       div_step;
		logic       gate;
		logic       gap;
		logic       load_out;
		logic [1:0] slot;
		logic       last;
	} ctl_cmd_t;

	typedef struct packed {
		logic cmd_none;
		logic echo_wrap;
	} dp_status_t;

endpackage : nae_pkg
`default_nettype wire

// ===== sv/note_articulation_event_generator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// note_articulation_event_generator
// Turns note, rest and echo commands into note, rest and relative volume
// events with quantized gate and release times.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  input     in_valid / in_ready    cmd, pitch, octave_num, ticks
//  output    out_valid / out_ready  event_kind, event_value, gate_ticks,
//                                   release_gap, last_of_run
//  config    cfg_we                 cfg_index, cfg_data
//
// One word is processed at a time. The input word is captured, then passes
// duration prep, multiply, the 24-step bit-serial quantize divide, gate and
// gap before its first result is registered. A word gives 1 to 3 results;
// an unused command code gives none.
// A stalled result holds its register and the input stays not ready until the
// last result of the word is taken. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module note_articulation_event_generator #(
	parameter int ECHO_DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [15:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         cmd,
	input  wire logic [7:0]         pitch,
	input  wire logic [3:0]         octave_num,
	input  wire logic [15:0]        ticks,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              event_kind,
	output logic signed [9:0]       event_value,
	output logic [15:0]             gate_ticks,
	output logic [15:0]             release_gap,
	output logic                    last_of_run
);

	import nae_pkg::*;

	ctl_cmd_t   ctl;
	dp_status_t status;

	nae_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.ctl       (ctl)
	);

	nae_datapath #(
		.ECHO_DEPTH (ECHO_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.pitch       (pitch),
		.octave_num  (octave_num),
		.ticks       (ticks),
		.ctl         (ctl),
		.status      (status),
		.event_kind  (event_kind),
		.event_value (event_value),
		.gate_ticks  (gate_ticks),
		.release_gap (release_gap),
		.last_of_run (last_of_run)
	);

	// The block never takes a new word while a result is being offered.
	a_ready_excludes_valid: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("input ready while a result is pending");

	// The last word of a run ends the output burst.
	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_of_run) |=> !out_valid)
		else $error("result offered after the last word of a run");

	// A word that is not the last is always followed by another one.
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_of_run) |=> out_valid)
		else $error("run ended without a last word");

	// Volume events carry no timing.
	a_volume_no_timing: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (event_kind == KIND_VOLUME)) |->
		((gate_ticks == 16'd0) && (release_gap == 16'd0)))
		else $error("volume event with nonzero timing");

endmodule : note_articulation_event_generator
`default_nettype wire

// ===== sv/nae_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nae_ram
// Generic single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
module nae_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule : nae_ram
`default_nettype wire

// ===== sv/nae_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nae_datapath
// Configuration registers, duration and shuffle arithmetic, echo history,
// quantize multiply and bit-serial divide, gate/gap and the output register.
// ----------------------------------------------------------------------------
module nae_datapath #(
	parameter int ECHO_DEPTH = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [2:0]           cfg_index,
	input  wire logic [15:0]          cfg_data,
	input  wire logic [1:0]           cmd,
	input  wire logic [7:0]           pitch,
	input  wire logic [3:0]           octave_num,
	input  wire logic [15:0]          ticks,
	input  wire nae_pkg::ctl_cmd_t    ctl,
	output nae_pkg::dp_status_t       status,
	output logic [1:0]                event_kind,
	output logic signed [9:0]         event_value,
	output logic [15:0]               gate_ticks,
	output logic [15:0]               release_gap,
	output logic                      last_of_run
);

	import nae_pkg::*;

	localparam int AW = (ECHO_DEPTH > 1) ? $clog2(ECHO_DEPTH) : 1;
	localparam int FW = $clog2(ECHO_DEPTH + 1);
	localparam int CW = (FW > 5) ? FW : 5;
	localparam int XW = CW + 1;

	// Configuration registers.
	logic [15:0]       default_ticks_q;
	logic [7:0]        quant_num_q;
	logic [7:0]        quant_den_q;
	logic [15:0]       release_ticks_q;
	logic              drum_enable_q;
	logic [15:0]       shuffle_amount_q;
	logic [4:0]        echo_offset_q;
	logic [8:0]        echo_attenuation_q;

	// Item state.
	logic [1:0]        cmd_q;
	logic [7:0]        pitch_q;
	logic [3:0]        oct_q;
	logic [15:0]       ticks_q;
	logic [15:0]       dur_q;
	logic              echo_hit_q;
	logic              main_tone_q;
	logic [8:0]        main_note_q;
	logic [PROD_W-1:0] div_q;
	logic [7:0]        rem_q;
	logic [15:0]       gate_q;
	logic [15:0]       gap_q;

	// Persistent state.
	logic              shuffle_neg_q;
	logic [AW-1:0]     wp_q;
	logic [FW-1:0]     fill_q;

	// Output register.
	logic [1:0]        kind_q;
	logic [9:0]        value_q;
	logic [15:0]       out_gate_q;
	logic [15:0]       out_gap_q;
	logic              last_q;

	logic [15:0]       t_eff;
	logic [16:0]       amt17;
	logic [16:0]       sh17;
	logic [17:0]       sum18;
	logic [15:0]       dur_next;
	logic [7:0]        oct_semis;
	logic [8:0]        note;
	logic [CW-1:0]     off_c;
	logic [CW-1:0]     fill_c;
	logic [XW-1:0]     rd_diff;
	logic [XW-1:0]     rd_idx;
	logic              hit;
	logic              push;
	logic [8:0]        ram_rdata;
	logic [8:0]        rem_shift;
	logic              rem_ge;
	logic [8:0]        rem_next;
	logic [15:0]       gate_next;
	logic [9:0]        att10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_ticks_q    <= DEFAULT_TICKS_RST;
			quant_num_q        <= QUANT_NUM_RST;
			quant_den_q        <= QUANT_DEN_RST;
			release_ticks_q    <= '0;
			drum_enable_q      <= 1'b0;
			shuffle_amount_q   <= '0;
			echo_offset_q      <= '0;
			echo_attenuation_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEFAULT_TICKS:    default_ticks_q    <= cfg_data;
				REG_QUANT_NUM:        quant_num_q        <= cfg_data[7:0];
				REG_QUANT_DEN:        quant_den_q        <= cfg_data[7:0];
				REG_RELEASE_TICKS:    release_ticks_q    <= cfg_data;
				REG_DRUM_ENABLE:      drum_enable_q      <= cfg_data[0];
				REG_SHUFFLE_AMOUNT:   shuffle_amount_q   <= cfg_data;
				REG_ECHO_OFFSET:      echo_offset_q      <= cfg_data[4:0];
				REG_ECHO_ATTENUATION: echo_attenuation_q <= cfg_data[8:0];
				default:              ;
			endcase
		end
	end

	// Effective duration: default substitution, alternating shuffle, clamp.
	always_comb begin
		t_eff = (ticks_q == 16'd0) ? default_ticks_q : ticks_q;
		amt17 = {shuffle_amount_q[15], shuffle_amount_q};
		sh17  = shuffle_neg_q ? (17'd0 - amt17) : amt17;
		sum18 = {2'b00, t_eff} + {sh17[16], sh17};
		if (sum18[17]) begin
			dur_next = 16'd0;
		end else if (sum18[16]) begin
			dur_next = 16'hFFFF;
		end else begin
			dur_next = sum18[15:0];
		end
	end

	always_comb begin
		oct_semis = {4'd0, oct_q} * SEMITONES;
		note      = {1'b0, pitch_q} + (drum_enable_q ? 9'd0 : {1'b0, oct_semis});
	end

	// Echo lookup in the circular history: the newest push sits just behind the
	// write pointer, so the entry n pushes back is at wp - n, modulo the depth.
	always_comb begin
		off_c   = (CW'(echo_offset_q) > CW'(ECHO_DEPTH)) ? CW'(ECHO_DEPTH)
		                                                  : CW'(echo_offset_q);
		fill_c  = CW'(fill_q);
		hit     = (off_c != '0) && (off_c <= fill_c);
		rd_diff = XW'(wp_q) - XW'(off_c);
		rd_idx  = rd_diff[XW-1] ? (rd_diff + XW'(ECHO_DEPTH)) : rd_diff;
		push    = ctl.prep && ((cmd_q == CMD_NOTE) || (cmd_q == CMD_REST));
	end

	nae_ram #(
		.WIDTH (9),
		.DEPTH (ECHO_DEPTH),
		.AW    (AW)
	) u_history (
		.clk   (clk),
		.we    (push),
		.waddr (wp_q),
		.wdata ((cmd_q == CMD_NOTE) ? note : 9'd0),
		.raddr (rd_idx[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shuffle_neg_q <= 1'b0;
			wp_q          <= '0;
			fill_q        <= '0;
		end else if (ctl.prep && !status.cmd_none) begin
			shuffle_neg_q <= !shuffle_neg_q;
			if (push) begin
				wp_q <= (wp_q == AW'(ECHO_DEPTH - 1)) ? '0 : wp_q + AW'(1);
				if (fill_q != FW'(ECHO_DEPTH)) begin
					fill_q <= fill_q + FW'(1);
				end
			end
		end
	end

	// One step of the restoring divide.
	always_comb begin
		rem_shift = {rem_q, div_q[PROD_W-1]};
		rem_ge    = rem_shift >= {1'b0, quant_den_q};
		rem_next  = rem_ge ? (rem_shift - {1'b0, quant_den_q}) : rem_shift;
	end

	always_comb begin
		if (release_ticks_q != 16'd0) begin
			gate_next = (release_ticks_q >= dur_q) ? 16'd1 : (dur_q - release_ticks_q);
		end else if (quant_den_q == 8'd0) begin
			gate_next = dur_q;
		end else if (div_q[PROD_W-1:16] != '0) begin
			gate_next = 16'hFFFF;
		end else begin
			gate_next = div_q[15:0];
		end
	end

	assign att10 = {echo_attenuation_q[8], echo_attenuation_q};

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q   <= cmd;
			pitch_q <= pitch;
			oct_q   <= octave_num;
			ticks_q <= ticks;
		end
		if (ctl.prep) begin
			dur_q      <= dur_next;
			echo_hit_q <= hit;
		end
		if (ctl.mul) begin
			div_q <= dur_q * quant_num_q;
			rem_q <= '0;
			if (cmd_q == CMD_NOTE) begin
				main_tone_q <= 1'b1;
				main_note_q <= note;
			end else begin
				main_tone_q <= (cmd_q == CMD_ECHO) && echo_hit_q && (ram_rdata != 9'd0);
				main_note_q <= ram_rdata;
			end
		end
		if (ctl.div_step) begin
			div_q <= {div_q[PROD_W-2:0], rem_ge};
			rem_q <= rem_next[7:0];
		end
		if (ctl.gate) begin
			gate_q <= gate_next;
		end
		if (ctl.gap) begin
			gap_q <= (gate_q > dur_q) ? 16'd0 : (dur_q - gate_q);
		end
		if (ctl.load_out) begin
			last_q <= ctl.last;
			unique case (ctl.slot)
				SLOT_PRE: begin
					kind_q     <= KIND_VOLUME;
					value_q    <= 10'd0 - att10;
					out_gate_q <= '0;
					out_gap_q  <= '0;
				end
				SLOT_POST: begin
					kind_q     <= KIND_VOLUME;
					value_q    <= att10;
					out_gate_q <= '0;
					out_gap_q  <= '0;
				end
				default: begin
					if (main_tone_q) begin
						kind_q     <= KIND_NOTE;
						value_q    <= {1'b0, main_note_q};
						out_gate_q <= gate_q;
						out_gap_q  <= gap_q;
					end else begin
						kind_q     <= KIND_REST;
						value_q    <= '0;
						out_gate_q <= '0;
						out_gap_q  <= dur_q;
					end
				end
			endcase
		end
	end

	assign status.cmd_none  = (cmd_q == CMD_NONE);
	assign status.echo_wrap = (cmd_q == CMD_ECHO) && (echo_attenuation_q != 9'd0);

	assign event_kind  = kind_q;
	assign event_value = value_q;
	assign gate_ticks  = out_gate_q;
	assign release_gap = out_gap_q;
	assign last_of_run = last_q;

endmodule : nae_datapath
`default_nettype wire

// ===== sv/nae_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nae_ctrl
// Controller: sequences capture, duration, multiply, the 24-step divide,
// gate and gap, and hands out the one to three output words of an item.
// ----------------------------------------------------------------------------
module nae_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire logic                out_ready,
	input  wire nae_pkg::dp_status_t status,
	output nae_pkg::ctl_cmd_t        ctl
);

	import nae_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PREP  = 3'd1;
	localparam logic [2:0] S_MUL   = 3'd2;
	localparam logic [2:0] S_DIV   = 3'd3;
	localparam logic [2:0] S_GATE  = 3'd4;
	localparam logic [2:0] S_GAP   = 3'd5;
	localparam logic [2:0] S_FIRST = 3'd6;
	localparam logic [2:0] S_EMIT  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [4:0] cnt_q;
	logic [1:0] slot_q;
	logic [1:0] slot_d;

	always_comb begin
		state_d      = state_q;
		slot_d       = slot_q;
		ctl          = '0;
		ctl.capture  = (state_q == S_IDLE) && in_valid;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				ctl.prep = 1'b1;
				state_d  = status.cmd_none ? S_IDLE : S_MUL;
			end
			S_MUL: begin
				ctl.mul = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				ctl.div_step = 1'b1;
				if (cnt_q == DIV_LAST) begin
					state_d = S_GATE;
				end
			end
			S_GATE: begin
				ctl.gate = 1'b1;
				state_d  = S_GAP;
			end
			S_GAP: begin
				ctl.gap = 1'b1;
				state_d = S_FIRST;
			end
			S_FIRST: begin
				ctl.load_out = 1'b1;
				slot_d       = status.echo_wrap ? SLOT_PRE : SLOT_MAIN;
				state_d      = S_EMIT;
			end
			S_EMIT: begin
				if (out_ready) begin
					if (slot_q == SLOT_PRE) begin
						ctl.load_out = 1'b1;
						slot_d       = SLOT_MAIN;
					end else if ((slot_q == SLOT_MAIN) && status.echo_wrap) begin
						ctl.load_out = 1'b1;
						slot_d       = SLOT_POST;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		ctl.slot = slot_d;
		ctl.last = (slot_d == SLOT_POST) || ((slot_d == SLOT_MAIN) && !status.echo_wrap);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			slot_q  <= SLOT_MAIN;
		end else begin
			state_q <= state_d;
			slot_q  <= slot_d;
			if (state_q == S_DIV) begin
				cnt_q <= cnt_q + 5'd1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_EMIT);

endmodule : nae_ctrl
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the note articulation event generator. A short
// table of directed words and register writes comes first. Random phases with
// fresh register settings and different amounts of idling on both channels
// follow. Every event is compared field by field against an in-bench model or a listed event.
// ----------------------------------------------------------------------------
module tb_top;
	import nae_pkg::*;

	localparam int HIST_DEPTH    = 16;
	localparam int DRAIN_CYCLES  = 40;
	localparam int CYCLE_LIMIT   = 300000;
	localparam int PRESSURE_HOLD = 400;
	localparam int PHASES        = 6;
	localparam int PHASE_WORDS   = 32;

	typedef struct {
		logic [1:0]        kind;
		logic signed [9:0] value;
		logic [15:0]       gate;
		logic [15:0]       gap;
		logic              last;
	} event_t;

	// One row of the directed table: a register write or a command word.
	// typed < 0 means the model predicts; otherwise typed events are listed.
	typedef struct {
		bit          is_reg;
		logic [2:0]  idx;
		logic [15:0] val;
		logic [1:0]  c;
		logic [7:0]  p;
		logic [3:0]  o;
		logic [15:0] t;
		int          typed;
		event_t      want;
	} step_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [2:0]        cfg_index;
	logic [15:0]       cfg_data;
	logic              in_valid;
	logic              in_ready;
	logic [1:0]        cmd;
	logic [7:0]        pitch;
	logic [3:0]        octave_num;
	logic [15:0]       ticks;
	logic              out_valid;
	logic              out_ready;
	logic [1:0]        event_kind;
	logic signed [9:0] event_value;
	logic [15:0]       gate_ticks;
	logic [15:0]       release_gap;
	logic              last_of_run;

	note_articulation_event_generator #(.ECHO_DEPTH(HIST_DEPTH)) uut (.*);

	// Model copy of the registers, at their reset values.
	logic [15:0]        dflt_ticks = DEFAULT_TICKS_RST;
	logic [7:0]         q_num      = QUANT_NUM_RST;
	logic [7:0]         q_den      = QUANT_DEN_RST;
	logic [15:0]        rel_ticks  = 16'd0;
	logic               drum       = 1'b0;
	logic signed [15:0] swing      = 16'sd0;
	logic [4:0]         echo_back  = 5'd0;
	logic signed [8:0]  echo_vol   = 9'sd0;

	// Model copy of the state.
	bit         negate_next = 1'b0;
	logic [8:0] hist [HIST_DEPTH];
	int         hist_count  = 0;

	event_t expected_events [$];
	event_t want;

	int snd_idle       = 0;
	int rcv_stall      = 0;
	int hold_len       = 0;
	int hold_seq       = 0;
	int cycle_count    = 0;
	int words_sent     = 0;
	int directed_words = 0;
	int events_checked = 0;
	int mismatches     = 0;
	int settings_used  = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timed out after %0d cycles with %0d events outstanding.",
			cycle_count, expected_events.size());
		$display("CHECKS FAILED");
		$finish;
	end

	// Receiver: random stalls, plus a long hold-off when one is requested.
	initial begin : receiver
		int hold_left;
		int seen;
		hold_left = 0;
		seen = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seq != seen) begin
				seen = hold_seq;
				hold_left = hold_len;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= rcv_stall);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_events.size() == 0) begin
				$error("event with nothing expected: event_kind %0d, event_value %0d",
					event_kind, event_value);
				mismatches++;
			end else begin
				want = expected_events.pop_front();
				events_checked++;
				if (event_kind !== want.kind) begin
					$error("event_kind: expected %0d, actual %0d", want.kind, event_kind);
					mismatches++;
				end
				if (event_value !== want.value) begin
					$error("event_value: expected %0d, actual %0d", want.value, event_value);
					mismatches++;
				end
				if (gate_ticks !== want.gate) begin
					$error("gate_ticks: expected %0d, actual %0d", want.gate, gate_ticks);
					mismatches++;
				end
				if (release_gap !== want.gap) begin
					$error("release_gap: expected %0d, actual %0d", want.gap, release_gap);
					mismatches++;
				end
				if (last_of_run !== want.last) begin
					$error("last_of_run: expected %0d, actual %0d", want.last, last_of_run);
					mismatches++;
				end
			end
		end
	end

	function automatic event_t make_event(input logic [1:0] k, input logic signed [9:0] v,
			input int unsigned g, input int unsigned r);
		event_t e;
		e.kind = k;
		e.value = v;
		e.gate = g[15:0];
		e.gap = r[15:0];
		e.last = 1'b0;
		return e;
	endfunction

	// Release time wins over quantize when it is set.
	function automatic int unsigned gate_time(input int unsigned d);
		int unsigned q;
		if (rel_ticks != 0)
			return (rel_ticks >= d) ? 1 : d - rel_ticks;
		if (q_den == 0)
			return d;
		q = (d * q_num) / q_den;
		return (q > 65535) ? 65535 : q;
	endfunction

	function automatic event_t tone_event(input logic [8:0] note, input int unsigned d);
		int unsigned g;
		g = gate_time(d);
		return make_event(KIND_NOTE, {1'b0, note}, g, (g > d) ? 0 : d - g);
	endfunction

	function automatic void remember_note(input logic [8:0] v);
		for (int i = HIST_DEPTH - 1; i > 0; i--)
			hist[i] = hist[i - 1];
		hist[0] = v;
		if (hist_count < HIST_DEPTH)
			hist_count++;
	endfunction

	// Works out the events of one command word and advances the model state.
	function automatic void articulate(input logic [1:0] c, input logic [7:0] p,
			input logic [3:0] o, input logic [15:0] t, input bit keep);
		event_t ev [3];
		int n;
		int sum;
		int unsigned d;
		int unsigned back;
		logic [8:0] note;
		n = 0;
		if (c == CMD_NONE)
			return;
		if (t == 0)
			t = dflt_ticks;
		sum = int'(t) + (negate_next ? -int'(swing) : int'(swing));
		if (sum < 0)
			d = 0;
		else if (sum > 65535)
			d = 65535;
		else
			d = sum;
		negate_next = !negate_next;
		case (c)
			CMD_NOTE: begin
				note = p + (drum ? 9'd0 : o * SEMITONES);
				remember_note(note);
				ev[n] = tone_event(note, d);
				n++;
			end
			CMD_REST: begin
				remember_note(9'd0);
				ev[n] = make_event(KIND_REST, 10'sd0, 0, d);
				n++;
			end
			default: begin
				back = (echo_back > HIST_DEPTH) ? HIST_DEPTH : echo_back;
				note = 9'd0;
				if (echo_vol != 0) begin
					ev[n] = make_event(KIND_VOLUME, 10'(-int'(echo_vol)), 0, 0);
					n++;
				end
				if (back != 0 && back <= hist_count)
					note = hist[back - 1];
				if (note == 0)
					ev[n] = make_event(KIND_REST, 10'sd0, 0, d);
				else
					ev[n] = tone_event(note, d);
				n++;
				if (echo_vol != 0) begin
					ev[n] = make_event(KIND_VOLUME, 10'(int'(echo_vol)), 0, 0);
					n++;
				end
			end
		endcase
		for (int i = 0; i < n; i++) begin
			ev[i].last = (i == n - 1);
			if (keep)
				expected_events.insert(expected_events.size(), ev[i]);
		end
	endfunction

	function automatic logic [15:0] pick_ticks();
		case ($urandom_range(9))
			0: return 16'd0;
			1: return 16'hFFFF;
			2, 3, 4, 5: return 16'($urandom_range(1, 300));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic step_t reg_row(input logic [2:0] idx, input logic [15:0] val);
		step_t s;
		s = '{default: 0, want: make_event(KIND_NOTE, 10'sd0, 0, 0)};
		s.is_reg = 1'b1;
		s.idx = idx;
		s.val = val;
		return s;
	endfunction

	function automatic step_t typed_row(input logic [1:0] c, input logic [7:0] p,
			input logic [3:0] o, input logic [15:0] t, input int typed,
			input logic [1:0] k, input logic signed [9:0] v,
			input int unsigned g, input int unsigned r);
		step_t s;
		s = reg_row(3'd0, 16'd0);
		s.is_reg = 1'b0;
		s.c = c;
		s.p = p;
		s.o = o;
		s.t = t;
		s.typed = typed;
		s.want = make_event(k, v, g, r);
		s.want.last = 1'b1;
		return s;
	endfunction

	function automatic step_t word_row(input logic [1:0] c, input logic [7:0] p,
			input logic [3:0] o, input logic [15:0] t);
		return typed_row(c, p, o, t, -1, KIND_NOTE, 10'sd0, 0, 0);
	endfunction

	task automatic write_register(input logic [2:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_DEFAULT_TICKS:    dflt_ticks = val;
			REG_QUANT_NUM:        q_num = val[7:0];
			REG_QUANT_DEN:        q_den = val[7:0];
			REG_RELEASE_TICKS:    rel_ticks = val;
			REG_DRUM_ENABLE:      drum = val[0];
			REG_SHUFFLE_AMOUNT:   swing = val;
			REG_ECHO_OFFSET:      echo_back = val[4:0];
			REG_ECHO_ATTENUATION: echo_vol = val[8:0];
			default: ;
		endcase
	endtask

	task automatic send_word(input logic [1:0] c, input logic [7:0] p,
			input logic [3:0] o, input logic [15:0] t);
		while ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		pitch <= p;
		octave_num <= o;
		ticks <= t;
		do
			@(posedge clk);
		while (!in_ready);
		words_sent++;
	endtask

	// Waits for every expected event, then lets a command that gives no event
	// run out before registers are touched.
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Flavor 1 loads the low extremes, 2 the high ones, anything else random.
	// Random values carry junk above the width of the narrow registers.
	task automatic load_settings(input int flavor);
		logic [15:0] dt, qn, qd, rt, dr, sw, eo, ea;
		case (flavor)
			1: begin
				dt = 16'd0; qn = 16'd1; qd = 16'd255; rt = 16'd0;
				dr = 16'd0; sw = 16'h8000; eo = 16'd16; ea = 16'h0101;
			end
			2: begin
				dt = 16'hFFFF; qn = 16'd255; qd = 16'd1; rt = 16'hFFFF;
				dr = 16'd1; sw = 16'h7FFF; eo = 16'd31; ea = 16'h00FF;
			end
			default: begin
				dt = pick_ticks();
				qd = 16'($urandom_range(1, 255));
				qn = 16'($urandom_range(1, qd));
				case ($urandom_range(9))
					0: qd = 16'd0;
					1: qn = 16'($urandom_range(0, 255));
					default: ;
				endcase
				qn = {8'($urandom), qn[7:0]};
				qd = {8'($urandom), qd[7:0]};
				rt = ($urandom_range(2) == 0) ? pick_ticks() : 16'd0;
				dr = 16'($urandom);
				case ($urandom_range(5))
					0: sw = 16'h8000;
					1: sw = 16'h7FFF;
					2, 3: sw = 16'(int'($urandom_range(0, 200)) - 100);
					default: sw = 16'($urandom);
				endcase
				eo = ($urandom_range(3) == 0) ? 16'($urandom_range(0, 31))
				                              : 16'($urandom_range(1, 16));
				eo = {11'($urandom), eo[4:0]};
				case ($urandom_range(7))
					0, 1: ea = 16'd0;
					2: ea = 16'h0100;
					3: ea = 16'h00FF;
					4: ea = 16'h0001;
					default: ea = 16'($urandom);
				endcase
				if (ea[8:0] == 9'd0)
					ea = 16'd0;
				else
					ea = {7'($urandom), ea[8:0]};
			end
		endcase
		write_register(REG_DEFAULT_TICKS, dt);
		write_register(REG_QUANT_NUM, qn);
		write_register(REG_QUANT_DEN, qd);
		write_register(REG_RELEASE_TICKS, rt);
		write_register(REG_DRUM_ENABLE, dr);
		write_register(REG_SHUFFLE_AMOUNT, sw);
		write_register(REG_ECHO_OFFSET, eo);
		write_register(REG_ECHO_ATTENUATION, ea);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	initial begin : stimulus
		step_t directed [$];
		step_t row;
		bit writing;
		int snd_pct [PHASES];
		int rcv_pct [PHASES];
		int r;
		int n;
		logic [1:0] c;
		logic [7:0] p;
		logic [3:0] o;
		logic [15:0] t;

		snd_pct = '{0, 57, 0, 14, 0, 14};
		rcv_pct = '{0, 0, 57, 14, 0, 14};
		writing = 1'b0;
		for (int i = 0; i < HIST_DEPTH; i++)
			hist[i] = 9'd0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 3'd0;
		cfg_data = 16'd0;
		in_valid = 1'b0;
		cmd = CMD_NOTE;
		pitch = 8'd0;
		octave_num = 4'd0;
		ticks = 16'd0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: default length, full-length quantize, no echo.
		directed.insert(directed.size(), typed_row(CMD_NOTE, 8'd0, 4'd0, 16'd0, 1,
			KIND_NOTE, 10'sd0, 96, 0));
		directed.insert(directed.size(), typed_row(CMD_NOTE, 8'd255, 4'd15, 16'hFFFF, 1,
			KIND_NOTE, 10'sd435, 65535, 0));
		directed.insert(directed.size(), typed_row(CMD_REST, 8'd0, 4'd0, 16'd1, 1,
			KIND_REST, 10'sd0, 0, 1));
		directed.insert(directed.size(), typed_row(CMD_ECHO, 8'd0, 4'd0, 16'd10, 1,
			KIND_REST, 10'sd0, 0, 10));
		directed.insert(directed.size(), typed_row(CMD_NONE, 8'd1, 4'd1, 16'd5, 0,
			KIND_NOTE, 10'sd0, 0, 0));
		// Most negative shuffle; an unused command must not flip its sign.
		directed.insert(directed.size(), reg_row(REG_ECHO_OFFSET, 16'd2));
		directed.insert(directed.size(), reg_row(REG_ECHO_ATTENUATION, 16'h0100));
		directed.insert(directed.size(), reg_row(REG_SHUFFLE_AMOUNT, 16'h8000));
		directed.insert(directed.size(), word_row(CMD_ECHO, 8'd0, 4'd0, 16'd100));
		directed.insert(directed.size(), typed_row(CMD_NONE, 8'hAA, 4'h5, 16'h1234, 0,
			KIND_NOTE, 10'sd0, 0, 0));
		directed.insert(directed.size(), word_row(CMD_ECHO, 8'd0, 4'd0, 16'hFFFF));
		// Zero denominator with drum mode on.
		directed.insert(directed.size(), reg_row(REG_QUANT_DEN, 16'd0));
		directed.insert(directed.size(), reg_row(REG_SHUFFLE_AMOUNT, 16'd0));
		directed.insert(directed.size(), reg_row(REG_ECHO_ATTENUATION, 16'd0));
		directed.insert(directed.size(), reg_row(REG_DRUM_ENABLE, 16'd1));
		directed.insert(directed.size(), word_row(CMD_NOTE, 8'd200, 4'd15, 16'd1000));
		// Numerator above denominator saturates the gate.
		directed.insert(directed.size(), reg_row(REG_QUANT_DEN, 16'd3));
		directed.insert(directed.size(), reg_row(REG_QUANT_NUM, 16'd255));
		directed.insert(directed.size(), word_row(CMD_NOTE, 8'h55, 4'hA, 16'hFFFF));
		directed.insert(directed.size(), reg_row(REG_DEFAULT_TICKS, 16'd0));
		directed.insert(directed.size(), word_row(CMD_REST, 8'h0F, 4'h3, 16'd0));
		// Release at or above the duration.
		directed.insert(directed.size(), reg_row(REG_DEFAULT_TICKS, 16'hFFFF));
		directed.insert(directed.size(), reg_row(REG_RELEASE_TICKS, 16'hFFFF));
		directed.insert(directed.size(), word_row(CMD_NOTE, 8'd1, 4'd1, 16'd500));
		directed.insert(directed.size(), word_row(CMD_NOTE, 8'd2, 4'd2, 16'd0));
		directed.insert(directed.size(), reg_row(REG_RELEASE_TICKS, 16'd100));
		directed.insert(directed.size(), reg_row(REG_DRUM_ENABLE, 16'd0));
		directed.insert(directed.size(), word_row(CMD_NOTE, 8'hAA, 4'd3, 16'd1000));
		// Oversized echo offset: first beyond the history fill, then the oldest
		// entry once the history is full, which holds a zero note.
		directed.insert(directed.size(), reg_row(REG_ECHO_OFFSET, 16'd31));
		directed.insert(directed.size(), reg_row(REG_ECHO_ATTENUATION, 16'd255));
		directed.insert(directed.size(), word_row(CMD_ECHO, 8'd0, 4'd0, 16'd200));
		directed.insert(directed.size(), word_row(CMD_NOTE, 8'd11, 4'd7, 16'd300));
		directed.insert(directed.size(), word_row(CMD_NOTE, 8'h80, 4'd0, 16'd7));
		directed.insert(directed.size(), word_row(CMD_NOTE, 8'h7F, 4'hF, 16'd100));
		directed.insert(directed.size(), word_row(CMD_NOTE, 8'd5, 4'd8, 16'd2000));
		directed.insert(directed.size(), word_row(CMD_NOTE, 8'd40, 4'd6, 16'd0));
		directed.insert(directed.size(), word_row(CMD_NOTE, 8'd99, 4'd1, 16'd20000));
		directed.insert(directed.size(), word_row(CMD_NOTE, 8'd3, 4'd9, 16'd150));
		directed.insert(directed.size(), word_row(CMD_ECHO, 8'd0, 4'd0, 16'd64));
		directed.insert(directed.size(), reg_row(REG_ECHO_OFFSET, 16'd1));
		directed.insert(directed.size(), reg_row(REG_ECHO_ATTENUATION, 16'd1));
		directed.insert(directed.size(), word_row(CMD_ECHO, 8'd0, 4'd0, 16'd80));
		directed.insert(directed.size(), reg_row(REG_ECHO_OFFSET, 16'd3));
		directed.insert(directed.size(), word_row(CMD_ECHO, 8'd0, 4'd0, 16'd0));

		foreach (directed[i]) begin
			row = directed[i];
			if (row.is_reg) begin
				if (!writing)
					drain();
				write_register(row.idx, row.val);
				writing = 1'b1;
			end else begin
				if (writing) begin
					cfg_we <= 1'b0;
					writing = 1'b0;
					settings_used++;
				end
				send_word(row.c, row.p, row.o, row.t);
				articulate(row.c, row.p, row.o, row.t, row.typed < 0);
				if (row.typed == 1)
					expected_events.insert(expected_events.size(), row.want);
				directed_words++;
			end
		end
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			load_settings((ph < 2) ? ph + 1 : 0);
			snd_idle = snd_pct[ph];
			rcv_stall = rcv_pct[ph];
			// The receiver holds off long enough for the input side to back up.
			if (ph == 4) begin
				hold_len = PRESSURE_HOLD;
				hold_seq++;
			end
			n = 0;
			while (n < PHASE_WORDS) begin
				r = $urandom_range(19);
				c = (r == 0) ? CMD_NONE : (r < 10) ? CMD_NOTE : (r < 14) ? CMD_REST : CMD_ECHO;
				p = 8'($urandom);
				o = 4'($urandom);
				t = pick_ticks();
				send_word(c, p, o, t);
				articulate(c, p, o, t, 1'b1);
				if (c != CMD_NONE)
					n++;
			end
			drain();
		end

		$display("Sent %0d command words (%0d from the directed table) under %0d settings.",
			words_sent, directed_words, settings_used);
		$display("Compared %0d events field by field, %0d mismatches.",
			events_checked, mismatches);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
